>>> sv/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

    localparam int DATA_W = 32;
    localparam int NORM_W = 31;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SINGULAR = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_M0,
        ST_FWD_M1,
        ST_FWD_M2,
        ST_FWD_DIV,
        ST_ROW_END,
        ST_BS_RD,
        ST_BS_MUL,
        ST_BS_WR,
        ST_RS_RD,
        ST_RS_M0,
        ST_RS_M1,
        ST_RS_M2,
        ST_RS_M3,
        ST_OUT
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'(S32_MAX))
            r = S32_MAX;
        else if (v < 64'(S32_MIN))
            r = S32_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

>>> sv/tts_row_if.sv
`timescale 1ns / 1ps

interface tts_row_if;
    logic                                valid;
    logic                                ready;
    logic signed [tts_pkg::DATA_W-1:0]   lower_coef;
    logic signed [tts_pkg::DATA_W-1:0]   diag_coef;
    logic signed [tts_pkg::DATA_W-1:0]   upper_coef;
    logic signed [tts_pkg::DATA_W-1:0]   rhs_value;
    logic                                last_row;

    modport source (output valid, lower_coef, diag_coef, upper_coef, rhs_value, last_row,
                    input ready);
    modport sink (input valid, lower_coef, diag_coef, upper_coef, rhs_value, last_row,
                  output ready);
endinterface

>>> sv/tts_result_if.sv
`timescale 1ns / 1ps

interface tts_result_if;
    logic                                valid;
    logic                                ready;
    logic [tts_pkg::IDX_W-1:0]           row_index;
    logic signed [tts_pkg::DATA_W-1:0]   solution_value;
    logic [tts_pkg::NORM_W-1:0]          max_residual;
    logic [tts_pkg::STAT_W-1:0]          status;
    logic                                last_result;

    modport source (output valid, row_index, solution_value, max_residual, status,
                    last_result, input ready);
    modport sink (input valid, row_index, solution_value, max_residual, status,
                  last_result, output ready);
endinterface

>>> sv/tts_div.sv
`timescale 1ns / 1ps

module tts_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [tts_pkg::DATA_W-1:0]  dividend,
    input  logic signed [tts_pkg::DATA_W-1:0]  divisor,
    output logic                               done,
    output logic signed [tts_pkg::DATA_W-1:0]  quotient
);
    localparam int DW = tts_pkg::DATA_W;
    localparam int NW = DW + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW:0]        rem_reg;
    logic [NW-1:0]      num_reg;
    logic [DW-1:0]      den_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DW:0]        rem_shift;
    logic [DW+1:0]      diff;
    logic               ge;
    logic [DW-1:0]      mag_a;
    logic [DW-1:0]      mag_b;
    logic               q_big;

    assign rem_shift = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = ~diff[DW+1];
    assign mag_a     = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign mag_b     = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);

    // magnitude beyond 2^31 saturates either way; exactly 2^31 fits only when negative
    assign q_big = (|num_reg[NW-1:DW]) || (num_reg[DW-1] && (|num_reg[DW-2:0]));

    always_comb
    begin
        if (neg_reg)
            quotient = q_big ? tts_pkg::S32_MIN : DW'(-num_reg[DW-1:0]);
        else
            quotient = ((|num_reg[NW-1:DW]) || num_reg[DW-1]) ? tts_pkg::S32_MAX
                                                              : num_reg[DW-1:0];
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    done_reg <= 1'b0;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= {mag_a, {FRAC_BITS{1'b0}}};
            den_reg <= mag_b;
            neg_reg <= dividend[DW-1] ^ divisor[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW:0] : rem_shift;
            num_reg <= {num_reg[NW-2:0], ge};
        end
    end

endmodule

>>> sv/tridiagonal_thomas_solver_unit.sv
`timescale 1ns / 1ps

// Tridiagonal solver (Thomas algorithm), signed fixed point with FRAC_BITS fraction bits.
// Channel row: one matrix row per transfer (lower, diagonal, upper, right-hand side, last_row).
// Channel result: one solution value per unknown, ascending row order; the final one carries
// the residual infinity norm and last_result. A zero pivot or more than MAX_ROWS rows gives
// a single error result with status set instead of the solution.
// Rows are stored in a coefficient memory; ratio and offset (later the solution) in a second.
// Each row with a live sweep passes the multiply states FWD_M0, FWD_M1 and FWD_M2, then
// waits in FWD_DIV on the two parallel bit-serial dividers and closes in ROW_END. A row
// that is only stored goes from IDLE straight to ROW_END. After the last row,
// back-substitution runs BS_RD, BS_MUL and BS_WR per row; each result then passes RS_RD
// (memory read), RS_M0 to RS_M3 and OUT (presentation), and stays in OUT during a stall.
// A new row is taken only once the previous one and its results are finished.
// While the receiver stalls, the result is held and nothing else advances.
// Reset empties the system in progress; memory contents are not cleared, and no value read
// from them is used before being written.
module tridiagonal_thomas_solver_unit #(
    parameter int MAX_ROWS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    tts_row_if.sink        row,
    tts_result_if.source   result
);
    localparam int DW = tts_pkg::DATA_W;
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int SW = DW + 4;

    tts_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  rows_seen_reg;
    logic           singular_reg;
    logic           overflow_reg;

    logic signed [DW-1:0] l_reg, d_reg, u_reg, r_reg;
    logic                 last_reg;
    logic [AW-1:0]        row_idx_reg;
    logic [AW-1:0]        idx_reg;
    logic signed [DW-1:0] prev_ratio_reg, prev_off_reg, piv_reg;
    logic signed [63:0]   prod_reg;
    logic signed [DW-1:0] ratio_h_reg, off_h_reg;
    logic signed [DW-1:0] x_prev_reg, x_cur_reg, x_next_reg;
    logic signed [SW-1:0] acc_reg;
    logic [tts_pkg::NORM_W-1:0] norm_reg;

    logic [tts_pkg::IDX_W-1:0]  out_idx_reg;
    logic signed [DW-1:0]       out_sol_reg;
    logic [tts_pkg::NORM_W-1:0] out_norm_reg;
    logic [tts_pkg::STAT_W-1:0] out_stat_reg;
    logic                       out_last_reg;

    logic [4*DW-1:0] a_mem [MAX_ROWS];
    logic [2*DW-1:0] b_mem [MAX_ROWS];
    logic [4*DW-1:0] a_rdata_reg;
    logic [2*DW-1:0] b_rdata_reg;

    logic            a_we, a_re, b_we, b_re;
    logic [AW-1:0]   a_waddr, a_raddr, b_waddr, b_raddr;
    logic [2*DW-1:0] b_wdata;
    logic signed [DW-1:0] mul_a, mul_b;
    logic            div_start;

    logic                 room, accept, flagged, first_row, is_final, has_next;
    logic signed [DW-1:0] mulres, neg_u, rem_val, x_val;
    logic signed [DW-1:0] q_ratio, q_off;
    logic                 div_done, div_ratio_done, div_off_done;
    logic signed [SW-1:0] acc_total, res_val, res_abs;
    logic [tts_pkg::NORM_W-1:0] res_sat, norm_new;

    logic signed [DW-1:0] a_l, a_d, a_u, a_r;

    assign a_l = a_rdata_reg[4*DW-1:3*DW];
    assign a_d = a_rdata_reg[3*DW-1:2*DW];
    assign a_u = a_rdata_reg[2*DW-1:DW];
    assign a_r = a_rdata_reg[DW-1:0];

    assign room      = rows_seen_reg < CW'(MAX_ROWS);
    assign accept    = (state_reg == tts_pkg::ST_IDLE) && row.valid;
    assign flagged   = singular_reg || overflow_reg;
    assign first_row = (row_idx_reg == '0);
    assign is_final  = (CW'(idx_reg) + CW'(1)) == rows_seen_reg;
    assign has_next  = (CW'(idx_reg) + CW'(1)) < rows_seen_reg;

    assign mulres  = tts_pkg::sat_s32(prod_reg >>> FRAC_BITS);
    assign neg_u   = (u_reg == tts_pkg::S32_MIN) ? tts_pkg::S32_MAX : -u_reg;
    assign rem_val = tts_pkg::sat_s32(64'(r_reg) - 64'(mulres));
    assign x_val   = tts_pkg::sat_s32(64'(mulres) + 64'(off_h_reg));

    assign acc_total = acc_reg + SW'(mulres);
    assign res_val   = SW'(a_r) - acc_total;
    assign res_abs   = res_val[SW-1] ? -res_val : res_val;
    assign res_sat   = (res_abs > SW'(tts_pkg::S32_MAX)) ? {tts_pkg::NORM_W{1'b1}}
                                                         : res_abs[tts_pkg::NORM_W-1:0];
    assign norm_new  = (res_sat > norm_reg) ? res_sat : norm_reg;

    assign div_done = div_ratio_done && div_off_done;

    tts_div #(.FRAC_BITS(FRAC_BITS)) u_div_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (neg_u),
        .divisor  (piv_reg),
        .done     (div_ratio_done),
        .quotient (q_ratio)
    );

    tts_div #(.FRAC_BITS(FRAC_BITS)) u_div_off (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_val),
        .divisor  (piv_reg),
        .done     (div_off_done),
        .quotient (q_off)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[a_waddr] <= {row.lower_coef, row.diag_coef, row.upper_coef, row.rhs_value};
        if (a_re)
            a_rdata_reg <= a_mem[a_raddr];
        if (b_we)
            b_mem[b_waddr] <= b_wdata;
        if (b_re)
            b_rdata_reg <= b_mem[b_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tts_pkg::ST_IDLE:
                if (row.valid)
                    state_next = (room && !singular_reg) ? tts_pkg::ST_FWD_M0
                                                         : tts_pkg::ST_ROW_END;
            tts_pkg::ST_FWD_M0:  state_next = tts_pkg::ST_FWD_M1;
            tts_pkg::ST_FWD_M1:  state_next = tts_pkg::ST_FWD_M2;
            tts_pkg::ST_FWD_M2:
                state_next = (piv_reg == '0) ? tts_pkg::ST_ROW_END : tts_pkg::ST_FWD_DIV;
            tts_pkg::ST_FWD_DIV:
                if (div_done)
                    state_next = tts_pkg::ST_ROW_END;
            tts_pkg::ST_ROW_END:
                if (!last_reg)
                    state_next = tts_pkg::ST_IDLE;
                else if (flagged)
                    state_next = tts_pkg::ST_OUT;
                else
                    state_next = tts_pkg::ST_BS_RD;
            tts_pkg::ST_BS_RD:   state_next = tts_pkg::ST_BS_MUL;
            tts_pkg::ST_BS_MUL:  state_next = tts_pkg::ST_BS_WR;
            tts_pkg::ST_BS_WR:
                state_next = (idx_reg == '0) ? tts_pkg::ST_RS_RD : tts_pkg::ST_BS_RD;
            tts_pkg::ST_RS_RD:   state_next = tts_pkg::ST_RS_M0;
            tts_pkg::ST_RS_M0:   state_next = tts_pkg::ST_RS_M1;
            tts_pkg::ST_RS_M1:   state_next = tts_pkg::ST_RS_M2;
            tts_pkg::ST_RS_M2:   state_next = tts_pkg::ST_RS_M3;
            tts_pkg::ST_RS_M3:   state_next = tts_pkg::ST_OUT;
            tts_pkg::ST_OUT:
                if (result.ready)
                    state_next = out_last_reg ? tts_pkg::ST_IDLE : tts_pkg::ST_RS_RD;
            default:             state_next = tts_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        row.ready    = 1'b0;
        result.valid = 1'b0;
        a_we      = 1'b0;
        a_re      = 1'b0;
        b_we      = 1'b0;
        b_re      = 1'b0;
        a_waddr   = rows_seen_reg[AW-1:0];
        a_raddr   = idx_reg;
        b_waddr   = idx_reg;
        b_raddr   = idx_reg;
        b_wdata   = {ratio_h_reg, x_val};
        mul_a     = l_reg;
        mul_b     = '0;
        div_start = 1'b0;
        case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                row.ready = 1'b1;
                a_we      = row.valid && room;
            end
            tts_pkg::ST_FWD_M0:
                mul_b = first_row ? '0 : prev_ratio_reg;
            tts_pkg::ST_FWD_M1:
                mul_b = first_row ? '0 : prev_off_reg;
            tts_pkg::ST_FWD_M2:
                div_start = (piv_reg != '0);
            tts_pkg::ST_FWD_DIV:
            begin
                b_we    = div_done;
                b_waddr = row_idx_reg;
                b_wdata = {(last_reg ? DW'(0) : q_ratio), q_off};
            end
            tts_pkg::ST_BS_RD:
                b_re = 1'b1;
            tts_pkg::ST_BS_MUL:
            begin
                mul_a = b_rdata_reg[2*DW-1:DW];
                mul_b = x_next_reg;
            end
            tts_pkg::ST_BS_WR:
                b_we = 1'b1;
            tts_pkg::ST_RS_RD:
            begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                b_raddr = idx_reg + AW'(1);
            end
            tts_pkg::ST_RS_M0:
            begin
                mul_a = a_d;
                mul_b = x_cur_reg;
            end
            tts_pkg::ST_RS_M1:
            begin
                mul_a = a_l;
                mul_b = x_prev_reg;
            end
            tts_pkg::ST_RS_M2:
            begin
                mul_a = a_u;
                mul_b = x_next_reg;
            end
            tts_pkg::ST_OUT:
                result.valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign result.row_index      = out_idx_reg;
    assign result.solution_value = out_sol_reg;
    assign result.max_residual   = out_norm_reg;
    assign result.status         = out_stat_reg;
    assign result.last_result    = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tts_pkg::ST_IDLE;
            rows_seen_reg <= '0;
            singular_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (room)
                    rows_seen_reg <= rows_seen_reg + CW'(1);
                else
                    overflow_reg <= 1'b1;
            end
            if (state_reg == tts_pkg::ST_FWD_M2 && piv_reg == '0)
                singular_reg <= 1'b1;
            // end of solve: drop the row count and flags
            if ((state_reg == tts_pkg::ST_ROW_END && last_reg && flagged) ||
                (state_reg == tts_pkg::ST_RS_M3 && is_final))
            begin
                rows_seen_reg <= '0;
                singular_reg  <= 1'b0;
                overflow_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            tts_pkg::ST_IDLE:
                if (row.valid)
                begin
                    l_reg       <= row.lower_coef;
                    d_reg       <= row.diag_coef;
                    u_reg       <= row.upper_coef;
                    r_reg       <= row.rhs_value;
                    last_reg    <= row.last_row;
                    row_idx_reg <= rows_seen_reg[AW-1:0];
                end
            tts_pkg::ST_FWD_M1:
                piv_reg <= tts_pkg::sat_s32(64'(d_reg) + 64'(mulres));
            tts_pkg::ST_FWD_DIV:
                if (div_done)
                begin
                    prev_ratio_reg <= last_reg ? DW'(0) : q_ratio;
                    prev_off_reg   <= q_off;
                end
            tts_pkg::ST_ROW_END:
            begin
                idx_reg    <= AW'(rows_seen_reg - CW'(1));
                x_next_reg <= '0;
                norm_reg   <= '0;
                out_idx_reg  <= '0;
                out_sol_reg  <= '0;
                out_norm_reg <= '0;
                out_stat_reg <= overflow_reg ? tts_pkg::STATUS_OVERFLOW
                                             : tts_pkg::STATUS_SINGULAR;
                out_last_reg <= 1'b1;
            end
            tts_pkg::ST_BS_MUL:
            begin
                ratio_h_reg <= b_rdata_reg[2*DW-1:DW];
                off_h_reg   <= b_rdata_reg[DW-1:0];
            end
            tts_pkg::ST_BS_WR:
            begin
                x_next_reg <= x_val;
                if (idx_reg == '0)
                begin
                    x_cur_reg  <= x_val;
                    x_prev_reg <= '0;
                end
                else
                    idx_reg <= idx_reg - AW'(1);
            end
            tts_pkg::ST_RS_M0:
                x_next_reg <= has_next ? b_rdata_reg[DW-1:0] : DW'(0);
            tts_pkg::ST_RS_M1:
                acc_reg <= SW'(mulres);
            tts_pkg::ST_RS_M2:
                acc_reg <= acc_reg + SW'(mulres);
            tts_pkg::ST_RS_M3:
            begin
                norm_reg     <= norm_new;
                out_idx_reg  <= tts_pkg::IDX_W'(idx_reg);
                out_sol_reg  <= x_cur_reg;
                out_norm_reg <= is_final ? norm_new : '0;
                out_stat_reg <= tts_pkg::STATUS_OK;
                out_last_reg <= is_final;
            end
            tts_pkg::ST_OUT:
                if (result.ready && !out_last_reg)
                begin
                    idx_reg    <= idx_reg + AW'(1);
                    x_prev_reg <= x_cur_reg;
                    x_cur_reg  <= x_next_reg;
                end
            default:
            begin
            end
        endcase
    end

endmodule
